### hdl/bil_pkg.sv
// ----------------------------------------------------------------------------
// bil_pkg
// Shared codes and types for the bounded indexed list unit.
// ----------------------------------------------------------------------------
package bil_pkg;

  localparam int WordW = 32;
  localparam int PosW  = 5;
  localparam int FuncW = 3;
  localparam int CountW = 6;

  typedef enum logic [FuncW-1:0] {
    OP_INSERT_FRONT = 3'd0,
    OP_APPEND_BACK  = 3'd1,
    OP_DELETE       = 3'd2,
    OP_READ         = 3'd3,
    OP_OVERWRITE    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // control broadcast from the decoder to every cell
  typedef struct packed {
    logic            shift_up;  // insert at front
    logic            shift_dn;  // delete at pos
    logic            wr_pos;    // overwrite at pos
    logic            wr_tail;   // append at count
    logic [PosW-1:0] pos;
  } cell_ctrl_t;

endpackage

### hdl/bil_cell.sv
// ----------------------------------------------------------------------------
// bil_cell
// One storage cell of the list: shifts toward either neighbor or loads a word.
// ----------------------------------------------------------------------------
module bil_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic                      clk,
  input  bil_pkg::cell_ctrl_t       ctrl,
  input  logic [CW-1:0]             count,
  input  logic [bil_pkg::WordW-1:0] word_in,
  input  logic [bil_pkg::WordW-1:0] from_prev,
  input  logic [bil_pkg::WordW-1:0] from_next,
  output logic [bil_pkg::WordW-1:0] data
);
  import bil_pkg::*;

  logic [WordW-1:0] data_next;
  logic             at_pos;
  logic             above_pos;
  logic             at_tail;

  assign at_pos    = (IDX == int'(ctrl.pos));
  assign above_pos = (IDX >= int'(ctrl.pos));
  assign at_tail   = (IDX == int'(count));

  always_comb begin
    data_next = data;
    priority if (ctrl.shift_up) begin
      data_next = from_prev;
    end else if (ctrl.shift_dn && above_pos) begin
      data_next = from_next;
    end else if ((ctrl.wr_pos && at_pos) || (ctrl.wr_tail && at_tail)) begin
      data_next = word_in;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### hdl/bil_ctrl.sv
// ----------------------------------------------------------------------------
// bil_ctrl
// Request decoder: range and full checks, cell controls, status, next count.
// ----------------------------------------------------------------------------
module bil_ctrl #(
  parameter int CAPACITY = 32,
  parameter int CW       = 6
) (
  input  logic                      req,
  input  logic [bil_pkg::FuncW-1:0] func,
  input  logic [bil_pkg::PosW-1:0]  position,
  input  logic [CW-1:0]             count,
  output bil_pkg::cell_ctrl_t       ctrl,
  output bil_pkg::status_t          status,
  output logic                      rd_en,
  output logic [CW-1:0]             count_next
);
  import bil_pkg::*;

  logic [CW+PosW-1:0] pos_w;
  logic [CW+PosW-1:0] cnt_w;
  logic               in_range;
  logic               full;

  assign pos_w    = {{CW{1'b0}}, position};
  assign cnt_w    = {{PosW{1'b0}}, count};
  assign in_range = (pos_w < cnt_w) && (pos_w < (CW+PosW)'(CAPACITY));
  assign full     = (count == CW'(CAPACITY));

  always_comb begin
    ctrl       = '0;
    ctrl.pos   = position;
    status     = ST_OK;
    rd_en      = 1'b0;
    count_next = count;
    unique case (func)
      OP_INSERT_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.shift_up = req;
          count_next    = count + CW'(1);
        end
      end
      OP_APPEND_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.wr_tail = req;
          count_next   = count + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!in_range) begin
          status = ST_BAD_INDEX;
        end else begin
          ctrl.shift_dn = req;
          count_next    = count - CW'(1);
        end
      end
      OP_READ: begin
        if (!in_range) status = ST_BAD_INDEX;
        else rd_en = 1'b1;
      end
      OP_OVERWRITE: begin
        if (!in_range) status = ST_BAD_INDEX;
        else ctrl.wr_pos = req;
      end
      default: begin
        status = ST_BAD_INDEX;
      end
    endcase
  end

endmodule

### hdl/bounded_indexed_list_unit.sv
// ----------------------------------------------------------------------------
// bounded_indexed_list_unit
// Ordered list of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage: raise start with func, position and word_in; the request is taken at
// the clock edge where start is high and busy is low. busy stays low, so a
// request can be issued on every cycle.
// func: insert front, append back, delete at position, read at position,
// overwrite at position. Every request gets one result: done is high for
// exactly one cycle, the cycle after the request edge, with status, word_out
// (read data, zero unless a successful read) and count (elements held after
// the request). Throughput one request per cycle: every cell shifts or loads
// in parallel in the request cycle, and reads pick one of the first 32 cells
// through a single selector.
// The receiver cannot stall: a result not taken while done is high is lost.
// Reset (rst, synchronous) empties the list; cell contents are not cleared
// and are never visible, since only elements below count can be read.
// ----------------------------------------------------------------------------
module bounded_indexed_list_unit #(
  parameter int CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [bil_pkg::FuncW-1:0]  func,
  input  logic [bil_pkg::PosW-1:0]   position,
  input  logic signed [bil_pkg::WordW-1:0] word_in,
  output logic                       done,
  output logic [1:0]                 status,
  output logic signed [bil_pkg::WordW-1:0] word_out,
  output logic [bil_pkg::CountW-1:0] count
);
  import bil_pkg::*;

  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int NRead  = 1 << PosW;

  logic [WordW-1:0] data [CAPACITY];
  logic [WordW-1:0] rd_cells [NRead];

  logic            req;
  logic [CW-1:0]   elem_count;
  logic [CW-1:0]   elem_count_next;
  cell_ctrl_t      ctrl;
  status_t         status_next;
  logic            rd_en;
  logic [CW+CountW-1:0] count_ext;

  assign busy = 1'b0;
  assign req  = start && !busy;

  bil_ctrl #(.CAPACITY(CAPACITY), .CW(CW)) u_ctrl (
    .req       (req),
    .func      (func),
    .position  (position),
    .count     (elem_count),
    .ctrl      (ctrl),
    .status    (status_next),
    .rd_en     (rd_en),
    .count_next(elem_count_next)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WordW-1:0] prev_w;
    logic [WordW-1:0] next_w;
    if (g == 0) begin : g_head
      assign prev_w = word_in;
    end else begin : g_mid
      assign prev_w = data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_w = data[g];
    end else begin : g_body
      assign next_w = data[g+1];
    end
    bil_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (elem_count),
      .word_in  (word_in),
      .from_prev(prev_w),
      .from_next(next_w),
      .data     (data[g])
    );
  end

  // only the first 32 cells are addressable by position
  for (genvar k = 0; k < NRead; k++) begin : g_rd
    if (k < CAPACITY) begin : g_used
      assign rd_cells[k] = data[k];
    end else begin : g_none
      assign rd_cells[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= req;
      if (req) elem_count <= elem_count_next;
    end
  end

  assign count_ext = {{CountW{1'b0}}, elem_count_next};

  always_ff @(posedge clk) begin
    if (req) begin
      status   <= status_next;
      word_out <= rd_en ? rd_cells[position] : '0;
      count    <= count_ext[CountW-1:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    req |=> done)
    else $error("request without result");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(req))
    else $error("result without request");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (req && status_next == ST_FULL) |-> elem_count == CW'(CAPACITY))
    else $error("full status below capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    req |=> (elem_count == $past(elem_count) ||
             elem_count == $past(elem_count) + CW'(1) ||
             elem_count == $past(elem_count) - CW'(1)))
    else $error("count changed by more than one");

endmodule
